[rtl/lcdns_pkg.sv]
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types, request codes and constant tables for the character LCD
// nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  localparam int unsigned FifoDepth = 4;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_CMD    = 3'd1,
    ACT_DATA   = 3'd2,
    ACT_GOTO   = 3'd3,
    ACT_FIVE   = 3'd4,
    ACT_FOUR   = 3'd5,
    ACT_TWO    = 3'd6,
    ACT_SIGNED = 3'd7
  } action_e;

  // One queue entry: a whole byte (two events) or a single raw nibble event.
  typedef struct packed {
    logic       is_byte;
    logic       rs;
    logic [7:0] data;
    logic       strobe;
    logic [1:0] tail_wait;
    logic       last;
  } unit_t;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [3:0] RawWake   = 4'hF;
  localparam logic [3:0] RawThree  = 4'h3;
  localparam logic [3:0] RawTwo    = 4'h2;
  // ceil(2^19 / 10): exact quotient by ten for any 16-bit value
  localparam logic [15:0] RecipTen = 16'd52429;

  function automatic logic [13:0] pow10(input logic [2:0] pos);
    logic [13:0] p;
    case (pos)
      3'd0:    p = 14'd10000;
      3'd1:    p = 14'd1000;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd10;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h0C;
      3'd2:    c = 8'h06;
      3'd3:    c = 8'h01;
      default: c = 8'h80;
    endcase
    return c;
  endfunction

endpackage

[rtl/lcdns_fifo.sv]
// ----------------------------------------------------------------------------
// lcdns_fifo
// Short queue of byte/nibble entries between the request front end and the
// event back end.
// ----------------------------------------------------------------------------
module lcdns_fifo #(
  parameter int unsigned DEPTH = lcdns_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lcdns_pkg::unit_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output lcdns_pkg::unit_t  head_o,
  output logic              head_valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  lcdns_pkg::unit_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == CntFull);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/lcdns_front.sv]
// ----------------------------------------------------------------------------
// lcdns_front
// Breaks requests into queue entries, one per cycle while the queue has room:
// raw nibbles, command/data bytes, a sign and ASCII digits, a digit per step.
// ----------------------------------------------------------------------------
module lcdns_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [2:0]        action_i,
  input  logic [7:0]        byte_in_i,
  input  logic [5:0]        column_i,
  input  logic              row_i,
  input  logic [15:0]       value_i,
  output logic              push_o,
  output lcdns_pkg::unit_t  push_data_o,
  input  logic              full_i
);

  lcdns_pkg::action_e act_q;
  logic               busy_q;
  logic [3:0]         step_q;
  logic [7:0]         byte_q;
  logic [15:0]        rem_q, rem_d;
  logic               neg_q;
  logic [3:0]         tens_q;

  lcdns_pkg::unit_t   unit;
  logic               silent, is_last, use_digit, advance, done, accept;
  logic [2:0]         pos;
  logic [13:0]        pow;
  logic [3:0]         digit;
  logic [17:0]        digit_prod;
  logic [31:0]        quot_prod;
  logic [12:0]        quot;
  logic [7:0]         tens_x10;
  logic [3:0]         units;
  logic [15:0]        neg_value;

  // Digit at the current decimal position: count thresholds passed
  always_comb begin
    pow   = lcdns_pkg::pow10(pos);
    digit = '0;
    for (int unsigned k = 1; k < 10; k++) begin
      if ({1'b0, rem_q} >= 17'(k) * {3'b000, pow}) begin
        digit = 4'(k);
      end
    end
    digit_prod = 18'(digit) * 18'(pow);
    rem_d      = rem_q - digit_prod[15:0];
  end

  assign quot_prod = rem_q * lcdns_pkg::RecipTen;
  assign quot      = quot_prod[31:19];
  assign tens_x10  = {tens_q, 3'b000} + {3'b000, tens_q, 1'b0};
  assign units     = rem_q[3:0] - tens_x10[3:0];
  assign neg_value = 16'd0 - value_i;

  always_comb begin
    unit           = '0;
    unit.is_byte   = 1'b1;
    unit.strobe    = 1'b1;
    unit.tail_wait = 2'd1;
    silent         = 1'b0;
    is_last        = 1'b0;
    use_digit      = 1'b0;
    pos            = '0;
    case (act_q)
      lcdns_pkg::ACT_INIT: begin
        is_last = (step_q == 4'd9);
        if (step_q < 4'd5) begin
          unit.is_byte = 1'b0;
          unit.rs      = (step_q == 4'd0);
          unit.strobe  = (step_q != 4'd0);
          if (step_q == 4'd0) begin
            unit.data = {4'h0, lcdns_pkg::RawWake};
          end else if (step_q == 4'd4) begin
            unit.data = {4'h0, lcdns_pkg::RawTwo};
          end else begin
            unit.data = {4'h0, lcdns_pkg::RawThree};
          end
        end else begin
          unit.data      = lcdns_pkg::init_cmd(3'(step_q - 4'd5));
          unit.tail_wait = 2'd2;
        end
      end
      lcdns_pkg::ACT_CMD, lcdns_pkg::ACT_GOTO: begin
        unit.data = byte_q;
        is_last   = 1'b1;
      end
      lcdns_pkg::ACT_DATA: begin
        unit.rs   = 1'b1;
        unit.data = byte_q;
        is_last   = 1'b1;
      end
      lcdns_pkg::ACT_FIVE: begin
        unit.rs   = 1'b1;
        pos       = step_q[2:0];
        use_digit = 1'b1;
        unit.data = {lcdns_pkg::CharZero[7:4], digit};
        is_last   = (step_q == 4'd4);
      end
      lcdns_pkg::ACT_FOUR: begin
        // first step only reduces the value modulo ten thousand
        unit.rs   = 1'b1;
        pos       = step_q[2:0];
        use_digit = 1'b1;
        silent    = (step_q == 4'd0);
        unit.data = {lcdns_pkg::CharZero[7:4], digit};
        is_last   = (step_q == 4'd4);
      end
      lcdns_pkg::ACT_TWO: begin
        unit.rs = 1'b1;
        is_last = (step_q == 4'd1);
        if (step_q == 4'd0) begin
          unit.data = lcdns_pkg::CharZero + quot[7:0];
        end else begin
          unit.data = {lcdns_pkg::CharZero[7:4], units};
        end
      end
      lcdns_pkg::ACT_SIGNED: begin
        unit.rs = 1'b1;
        is_last = (step_q == 4'd5);
        pos     = 3'(step_q - 4'd1);
        if (step_q == 4'd0) begin
          unit.data = neg_q ? lcdns_pkg::CharMinus : lcdns_pkg::CharSpace;
        end else begin
          use_digit = 1'b1;
          silent    = (step_q == 4'd1);
          unit.data = {lcdns_pkg::CharZero[7:4], digit};
        end
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
    unit.last = is_last;
  end

  assign advance     = busy_q && (silent || !full_i);
  assign done        = advance && is_last;
  assign push_o      = advance && !silent;
  assign push_data_o = unit;
  assign req_ready_o = !busy_q || done;
  assign accept      = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      act_q  <= lcdns_pkg::ACT_INIT;
    end else if (accept) begin
      busy_q <= 1'b1;
      step_q <= '0;
      act_q  <= lcdns_pkg::action_e'(action_i);
    end else if (advance) begin
      busy_q <= !is_last;
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= value_i[15];
      if (lcdns_pkg::action_e'(action_i) == lcdns_pkg::ACT_GOTO) begin
        byte_q <= {1'b1, row_i, column_i};
      end else begin
        byte_q <= byte_in_i;
      end
      if (lcdns_pkg::action_e'(action_i) == lcdns_pkg::ACT_SIGNED && value_i[15]) begin
        rem_q <= neg_value;
      end else begin
        rem_q <= value_i;
      end
    end else if (advance) begin
      if (use_digit) begin
        rem_q <= rem_d;
      end
      // hold low bits of the quotient for the units character
      if (act_q == lcdns_pkg::ACT_TWO && step_q == 4'd0) begin
        tens_q <= quot[3:0];
      end
    end
  end

endmodule

[rtl/lcdns_back.sv]
// ----------------------------------------------------------------------------
// lcdns_back
// Expands queue entries into bus events, one per cycle, into an output
// register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module lcdns_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcdns_pkg::unit_t  head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  output logic              ev_valid_o,
  input  logic              ev_ready_i,
  output logic              reg_select_o,
  output logic [3:0]        nibble_o,
  output logic              strobe_res_o,
  output logic [1:0]        wait_units_o,
  output logic              last_o
);

  logic       valid_q;
  logic       low_q;
  logic       rs_q, strobe_q, last_q;
  logic [3:0] nib_q;
  logic [1:0] wait_q;

  logic       load, final_ev;
  logic [3:0] nib;
  logic       strobe, last;
  logic [1:0] wait_n;

  always_comb begin
    if (head_i.is_byte && !low_q) begin
      // high nibble of a byte: no wait, never the last event
      nib      = head_i.data[7:4];
      strobe   = 1'b1;
      wait_n   = 2'd0;
      last     = 1'b0;
      final_ev = 1'b0;
    end else begin
      nib      = head_i.data[3:0];
      strobe   = head_i.strobe;
      wait_n   = head_i.tail_wait;
      last     = head_i.last;
      final_ev = 1'b1;
    end
  end

  assign load  = head_valid_i && (!valid_q || ev_ready_i);
  assign pop_o = load && final_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      low_q   <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        low_q   <= !final_ev;
      end else if (ev_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rs_q     <= head_i.rs;
      nib_q    <= nib;
      strobe_q <= strobe;
      wait_q   <= wait_n;
      last_q   <= last;
    end
  end

  assign ev_valid_o   = valid_q;
  assign reg_select_o = rs_q;
  assign nibble_o     = nib_q;
  assign strobe_res_o = strobe_q;
  assign wait_units_o = wait_q;
  assign last_o       = last_q;

endmodule

[rtl/char_lcd_nibble_sequencer_top.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_top
// Turns LCD requests into the nibble events of a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one request per beat: tuser carries the request
//   kind, tdata the byte, cursor position and number. The master stream gives
//   one bus event per beat: tuser is register select, tdata the nibble, the
//   enable mode and the wait that follows; tlast marks the request's final
//   event. A request yields 2 to 15 events (power-up gives 15).
//   On an idle block the first event of a request passes the front end's request
//   registers, the entry queue and the output register; a four-digit print
//   first spends a silent step that only reduces the value.
//   Throughput: one event per cycle on the master side while the receiver is
//   ready. The front end fills the entry queue at one entry (byte or raw
//   nibble) per cycle while the queue has room, the back end drains it at one
//   event per cycle, so the back end sets the rate.
//   A new request is taken as soon as the front end has queued the previous
//   one's last entry, while its events still drain.
//   Reset empties the queue and the output register; nothing is emitted.
//   When the receiver stalls, the output beat holds, the queue fills and the
//   front end then stops taking requests.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_top #(
  parameter int unsigned FIFO_DEPTH = lcdns_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // byte_in[7:0], column[13:8], row[14], value[30:15]
  input  logic [2:0]  s_axis_tuser_i,   // action[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // nibble[3:0], strobe_res[4], wait_units[6:5]
  output logic        m_axis_tuser_o,   // reg_select[0]
  output logic        m_axis_tlast_o
);

  lcdns_pkg::unit_t push_data, head;
  logic             push, full, pop, head_valid;
  logic [3:0]       nibble;
  logic             strobe_res;
  logic [1:0]       wait_units;

  lcdns_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .action_i    (s_axis_tuser_i),
    .byte_in_i   (s_axis_tdata_i[7:0]),
    .column_i    (s_axis_tdata_i[13:8]),
    .row_i       (s_axis_tdata_i[14]),
    .value_i     (s_axis_tdata_i[30:15]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  lcdns_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  lcdns_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .ev_valid_o   (m_axis_tvalid_o),
    .ev_ready_i   (m_axis_tready_i),
    .reg_select_o (m_axis_tuser_o),
    .nibble_o     (nibble),
    .strobe_res_o (strobe_res),
    .wait_units_o (wait_units),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, wait_units, strobe_res, nibble};

endmodule
